### src/assert_macros.svh
// Assertion helpers used by the ray-cast unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge out of reset.
`define DGR_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// The antecedent in one cycle implies the consequent in the next one.
`define DGR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/dgr_pkg.sv
package dgr_pkg;

    localparam int MAP_SIDE  = 64;
    localparam int FRAC_BITS = 16;
    localparam int MAX_STEPS = 128;

    localparam int CELL_W = $clog2(MAP_SIDE);
    localparam int ADDR_W = 2 * CELL_W;
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int POS_W  = 22;
    localparam int DIR_W  = 18;
    localparam int CAM_W  = 18;
    localparam int DIST_W = 32;
    localparam int VAL_W  = 8;
    localparam int PROD_W = DIR_W + CAM_W;
    localparam int RD_W   = PROD_W - FRAC_BITS + 1;
    localparam int MAG_W  = RD_W - 1;
    localparam int FRAC_W = FRAC_BITS + 1;
    localparam int HALF_W = DIST_W / 2;
    localparam int CFG_W  = POS_W;
    localparam int CFG_AW = 3;

    localparam logic [CFG_AW-1:0] CFG_POS_X   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_POS_Y   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_DIR_X   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_DIR_Y   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_PLANE_X = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_PLANE_Y = 3'd5;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CAST  = 1'b1;

    localparam logic STATUS_HIT  = 1'b0;
    localparam logic STATUS_MISS = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DIR,
        ST_DIV_GO,
        ST_DIV,
        ST_SIDE_LO,
        ST_SIDE_HI,
        ST_STEP,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] quotient;
    } div_rsp_t;

endpackage

### src/dgr_ram.sv
module dgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### src/dgr_div.sv
// Restoring divider: floor(2^(2F) / divisor), one quotient bit per cycle,
// saturated to the distance width. A zero divisor yields all ones.
module dgr_div import dgr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [MAG_W-1:0] divisor,
    output div_rsp_t         rsp
);

    localparam int Q_W   = 2 * FRAC_BITS + 1;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [MAG_W-1:0] div_reg, div_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [MAG_W:0]   rem_shift;
    logic             ge;

    // The dividend is a single one followed by zeros, so only its top bit is set.
    assign rem_shift = {rem_reg, (cnt_reg == CNT_W'(Q_W))};
    assign ge        = rem_shift >= {1'b0, div_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start) begin
            cnt_next = CNT_W'(Q_W);
            div_next = divisor;
            rem_next = '0;
            q_next   = '0;
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? MAG_W'(rem_shift - {1'b0, div_reg}) : MAG_W'(rem_shift);
            q_next    = {q_reg[Q_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        div_reg <= div_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg[Q_W-1] ? '1 : q_reg[DIST_W-1:0];

endmodule

### src/dda_grid_raycast_unit.sv
// Map write: taken in the idle state without leaving it; the next word can follow at once.
// Ray cast: setup (multiply, direction, divider start, divide, side products), then a
// step and a map check per cell walked and a final step when the walk leaves the map or
// hits MAX_STEPS, then the output register is loaded once it is free.
// One item is in work at a time; a result stalled by m_tready holds off new words.
// Reset clears the 4096-cell map, taking no word; state and config registers reset at once.
module dda_grid_raycast_unit import dgr_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    // cell_x[5:0], cell_y[11:6], cell_value[19:12], camera_x[37:20], zero pad
    input  logic [39:0]        s_tdata,
    // func[0]
    input  logic [0:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // hit_x[5:0], hit_y[11:6], crossed_x_line[12], side_dist_x[44:13],
    // side_dist_y[76:45], delta_dist_x[108:77], delta_dist_y[140:109],
    // hit_value[148:141], zero pad
    output logic [151:0]       m_tdata,
    // status[0]
    output logic [0:0]         m_tuser
);

    `include "assert_macros.svh"

    state_t state_reg, state_next;

    logic [POS_W-1:0]        pos_x_reg, pos_y_reg;
    logic signed [DIR_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    logic signed [CAM_W-1:0]  cam_reg, cam_next;
    logic signed [PROD_W-1:0] prod_x_reg, prod_x_next, prod_y_reg, prod_y_next;
    logic signed [RD_W-1:0]   rdx_reg, rdx_next, rdy_reg, rdy_next;
    logic [DIST_W-1:0]        ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic [DIST_W-1:0]        sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic [FRAC_W-1:0]        frx_reg, frx_next, fry_reg, fry_next;
    logic [FRAC_W+HALF_W-1:0] lox_reg, lox_next, loy_reg, loy_next;
    logic [CELL_W-1:0]        mx_reg, mx_next, my_reg, my_next;
    logic [STEP_W-1:0]        n_reg, n_next;
    logic                     crossed_reg, crossed_next;
    logic                     status_reg, status_next;
    logic [VAL_W-1:0]         value_reg, value_next;
    logic [ADDR_W-1:0]        clr_reg, clr_next;

    logic                     out_valid_reg, out_valid_next;
    logic [151:0]             out_data_reg, out_data_next;
    logic                     out_status_reg, out_status_next;

    logic             s_acc;
    logic             div_start;
    logic [MAG_W-1:0] mag_x, mag_y;
    div_rsp_t         rsp_x, rsp_y;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [VAL_W-1:0]  ram_wdata, ram_rdata;

    logic                     step_x, out_of_map, start_inside;
    logic [CELL_W-1:0]        nx, ny;
    logic [FRAC_W+HALF_W-1:0] hix, hiy;
    logic [FRAC_W+HALF_W:0]   sumx, sumy;
    logic [DIST_W:0]          addx, addy;
    logic                     out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign div_start = (state_reg == ST_DIV_GO);
    assign out_free  = !out_valid_reg || m_tready;

    assign mag_x = rdx_reg[RD_W-1] ? MAG_W'(-rdx_reg) : MAG_W'(rdx_reg);
    assign mag_y = rdy_reg[RD_W-1] ? MAG_W'(-rdy_reg) : MAG_W'(rdy_reg);

    dgr_div u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (mag_x),
        .rsp     (rsp_x)
    );

    dgr_div u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (mag_y),
        .rsp     (rsp_y)
    );

    dgr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAP_SIDE * MAP_SIDE)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Walk step decision. A zero component is treated as a positive one.
    assign step_x = sdx_reg < sdy_reg;
    assign nx     = rdx_reg[RD_W-1] ? mx_reg - CELL_W'(1) : mx_reg + CELL_W'(1);
    assign ny     = rdy_reg[RD_W-1] ? my_reg - CELL_W'(1) : my_reg + CELL_W'(1);
    always_comb begin
        if (step_x) begin
            out_of_map = rdx_reg[RD_W-1] ? (mx_reg == '0)
                                         : (mx_reg == CELL_W'(MAP_SIDE - 1));
        end else begin
            out_of_map = rdy_reg[RD_W-1] ? (my_reg == '0)
                                         : (my_reg == CELL_W'(MAP_SIDE - 1));
        end
    end
    assign start_inside = (32'(pos_x_reg >> FRAC_BITS) < 32'(MAP_SIDE))
                       && (32'(pos_y_reg >> FRAC_BITS) < 32'(MAP_SIDE));

    assign ram_raddr = step_x ? ADDR_W'({my_reg, nx}) : ADDR_W'({ny, mx_reg});

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'({s_tdata[11:6], s_tdata[5:0]});
        ram_wdata = s_tdata[19:12];
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end else if (s_acc && (s_tuser[0] == FUNC_WRITE)) begin
            ram_we = 1'b1;
        end
    end

    // Upper half products of the side distance; the lower halves are registered.
    assign hix  = frx_reg * ddx_reg[DIST_W-1:HALF_W];
    assign hiy  = fry_reg * ddy_reg[DIST_W-1:HALF_W];
    assign sumx = (FRAC_W+HALF_W+1)'(hix) + (FRAC_W+HALF_W+1)'(lox_reg >> HALF_W);
    assign sumy = (FRAC_W+HALF_W+1)'(hiy) + (FRAC_W+HALF_W+1)'(loy_reg >> HALF_W);
    assign addx = (DIST_W+1)'(sdx_reg) + (DIST_W+1)'(ddx_reg);
    assign addy = (DIST_W+1)'(sdy_reg) + (DIST_W+1)'(ddy_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == '1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_acc && (s_tuser[0] == FUNC_CAST)) state_next = ST_MUL;
            end
            ST_MUL:     state_next = ST_DIR;
            ST_DIR:     state_next = ST_DIV_GO;
            ST_DIV_GO:  state_next = ST_DIV;
            ST_DIV: begin
                if (rsp_x.done && rsp_y.done) state_next = ST_SIDE_LO;
            end
            ST_SIDE_LO: state_next = ST_SIDE_HI;
            ST_SIDE_HI: state_next = start_inside ? ST_STEP : ST_DONE;
            ST_STEP: begin
                if ((n_reg == STEP_W'(MAX_STEPS)) || out_of_map) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: state_next = (ram_rdata != '0) ? ST_DONE : ST_STEP;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cam_next        = cam_reg;
        prod_x_next     = prod_x_reg;
        prod_y_next     = prod_y_reg;
        rdx_next        = rdx_reg;
        rdy_next        = rdy_reg;
        ddx_next        = ddx_reg;
        ddy_next        = ddy_reg;
        sdx_next        = sdx_reg;
        sdy_next        = sdy_reg;
        frx_next        = frx_reg;
        fry_next        = fry_reg;
        lox_next        = lox_reg;
        loy_next        = loy_reg;
        mx_next         = mx_reg;
        my_next         = my_reg;
        n_next          = n_reg;
        crossed_next    = crossed_reg;
        status_next     = status_reg;
        value_next      = value_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        case (state_reg)
            ST_CLEAR: clr_next = clr_reg + ADDR_W'(1);
            ST_IDLE: begin
                cam_next = $signed(s_tdata[37:20]);
            end
            ST_MUL: begin
                prod_x_next = plane_x_reg * cam_reg;
                prod_y_next = plane_y_reg * cam_reg;
            end
            ST_DIR: begin
                // Arithmetic shift rounds toward minus infinity.
                rdx_next = RD_W'(dir_x_reg) + RD_W'(prod_x_reg >>> FRAC_BITS);
                rdy_next = RD_W'(dir_y_reg) + RD_W'(prod_y_reg >>> FRAC_BITS);
            end
            ST_DIV: begin
                ddx_next = rsp_x.quotient;
                ddy_next = rsp_y.quotient;
                mx_next  = pos_x_reg[FRAC_BITS +: CELL_W];
                my_next  = pos_y_reg[FRAC_BITS +: CELL_W];
                frx_next = rdx_reg[RD_W-1]
                         ? FRAC_W'(pos_x_reg[FRAC_BITS-1:0])
                         : FRAC_W'(1 << FRAC_BITS) - FRAC_W'(pos_x_reg[FRAC_BITS-1:0]);
                fry_next = rdy_reg[RD_W-1]
                         ? FRAC_W'(pos_y_reg[FRAC_BITS-1:0])
                         : FRAC_W'(1 << FRAC_BITS) - FRAC_W'(pos_y_reg[FRAC_BITS-1:0]);
            end
            ST_SIDE_LO: begin
                lox_next = frx_reg * ddx_reg[HALF_W-1:0];
                loy_next = fry_reg * ddy_reg[HALF_W-1:0];
            end
            ST_SIDE_HI: begin
                sdx_next     = (sumx >> DIST_W) != '0 ? '1 : DIST_W'(sumx);
                sdy_next     = (sumy >> DIST_W) != '0 ? '1 : DIST_W'(sumy);
                n_next       = '0;
                crossed_next = 1'b0;
                status_next  = STATUS_MISS;
                value_next   = '0;
            end
            ST_STEP: begin
                if ((n_reg != STEP_W'(MAX_STEPS)) && !out_of_map) begin
                    n_next       = n_reg + STEP_W'(1);
                    crossed_next = step_x;
                    if (step_x) begin
                        mx_next  = nx;
                        sdx_next = addx[DIST_W] ? '1 : addx[DIST_W-1:0];
                    end else begin
                        my_next  = ny;
                        sdy_next = addy[DIST_W] ? '1 : addy[DIST_W-1:0];
                    end
                end
            end
            ST_CHECK: begin
                if (ram_rdata != '0) begin
                    value_next  = ram_rdata;
                    status_next = STATUS_HIT;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_data_next   = {3'b000, value_reg, ddy_reg, ddx_reg, sdy_reg,
                                       sdx_reg, crossed_reg, 6'(my_reg), 6'(mx_reg)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            pos_x_reg     <= POS_W'(2129920);
            pos_y_reg     <= POS_W'(2129920);
            dir_x_reg     <= -DIR_W'(65536);
            dir_y_reg     <= '0;
            plane_x_reg   <= '0;
            plane_y_reg   <= DIR_W'(43253);
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_POS_X:   pos_x_reg   <= cfg_wdata[POS_W-1:0];
                    CFG_POS_Y:   pos_y_reg   <= cfg_wdata[POS_W-1:0];
                    CFG_DIR_X:   dir_x_reg   <= cfg_wdata[DIR_W-1:0];
                    CFG_DIR_Y:   dir_y_reg   <= cfg_wdata[DIR_W-1:0];
                    CFG_PLANE_X: plane_x_reg <= cfg_wdata[DIR_W-1:0];
                    CFG_PLANE_Y: plane_y_reg <= cfg_wdata[DIR_W-1:0];
                    default: ;
                endcase
            end
        end
        cam_reg        <= cam_next;
        prod_x_reg     <= prod_x_next;
        prod_y_reg     <= prod_y_next;
        rdx_reg        <= rdx_next;
        rdy_reg        <= rdy_next;
        ddx_reg        <= ddx_next;
        ddy_reg        <= ddy_next;
        sdx_reg        <= sdx_next;
        sdy_reg        <= sdy_next;
        frx_reg        <= frx_next;
        fry_reg        <= fry_next;
        lox_reg        <= lox_next;
        loy_reg        <= loy_next;
        mx_reg         <= mx_next;
        my_reg         <= my_next;
        crossed_reg    <= crossed_next;
        status_reg     <= status_next;
        value_reg      <= value_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_status_reg;

    `DGR_ASSERT_ALWAYS(a_step_bound, aclk, aresetn, n_reg <= STEP_W'(MAX_STEPS))
    `DGR_ASSERT_ALWAYS(a_clear_blocks, aclk, aresetn, (state_reg != ST_CLEAR) || !s_tready)
    `DGR_ASSERT_NEXT(a_cast_starts, aclk, aresetn,
        s_acc && (s_tuser[0] == FUNC_CAST), state_reg == ST_MUL)
    `DGR_ASSERT_NEXT(a_done_loads, aclk, aresetn,
        (state_reg == ST_DONE) && out_free, m_tvalid && (state_reg == ST_IDLE))

endmodule
